// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile away when NO_ASSERTIONS
// is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// Checks that a consequent holds in the clock cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/pfx_eval_pkg.sv -----
// ---------------------------------------------------------------------------
// Postfix evaluator package
// Field widths, token codes, error codes and the microcode program of the
// postfix evaluator.
// ---------------------------------------------------------------------------
package pfx_eval_pkg;

  // Item field widths.
  localparam int VAR_IDX_W  = 5;
  localparam int VAR_W      = 32;
  localparam int TOK_W      = 8;
  localparam int HUND_W     = 39;
  localparam int ERR_W      = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int NUM_VARS   = 26;

  // Token characters.
  localparam logic [TOK_W-1:0] ASC_A     = 8'h41;
  localparam logic [TOK_W-1:0] ASC_Z     = 8'h5A;
  localparam logic [TOK_W-1:0] ASC_PLUS  = 8'h2B;
  localparam logic [TOK_W-1:0] ASC_MINUS = 8'h2D;
  localparam logic [TOK_W-1:0] ASC_STAR  = 8'h2A;
  localparam logic [TOK_W-1:0] ASC_SLASH = 8'h2F;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIVZERO   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd3;

  // Microcode addresses.
  typedef logic [4:0] upc_t;

  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_DECODE   = 5'd1;
  localparam upc_t U_CLASSIFY = 5'd2;
  localparam upc_t U_POP1     = 5'd3;
  localparam upc_t U_POP2     = 5'd4;
  localparam upc_t U_OPSEL    = 5'd5;
  localparam upc_t U_MDINIT   = 5'd6;
  localparam upc_t U_MDSTEP   = 5'd7;
  localparam upc_t U_MDFIN    = 5'd8;
  localparam upc_t U_ALU      = 5'd9;
  localparam upc_t U_PUSH     = 5'd10;
  localparam upc_t U_RDTOP    = 5'd11;
  localparam upc_t U_HUND     = 5'd12;
  localparam upc_t U_EMIT     = 5'd13;
  localparam upc_t U_REEMIT   = 5'd14;
  localparam upc_t U_LOADW    = 5'd15;
  localparam upc_t U_LETTER   = 5'd16;

  // Datapath action selected by one control word.
  typedef enum logic [3:0] {
    ACT_ACCEPT,
    ACT_NOP,
    ACT_LOAD,
    ACT_VAR,
    ACT_POP1,
    ACT_POP2,
    ACT_OPSEL,
    ACT_MDINIT,
    ACT_MDSTEP,
    ACT_MDFIN,
    ACT_ALU,
    ACT_PUSH,
    ACT_RDTOP,
    ACT_HUND,
    ACT_EMIT
  } action_t;

  // Jump condition; a false condition falls through to the next address.
  typedef enum logic [3:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_NO_ACCEPT,
    CND_IS_LOAD,
    CND_IS_LETTER,
    CND_NOT_MULDIV,
    CND_DIV_ZERO,
    CND_ITER_MORE,
    CND_NOT_LAST,
    CND_OUT_FREE
  } cond_t;

  typedef struct packed {
    action_t act;
    cond_t   cnd;
    upc_t    target;
  } ctrl_t;

  // Microcode program.
  function automatic ctrl_t ucode_rom(input upc_t addr);
    ctrl_t cw;
    unique case (addr)
      U_IDLE:     cw = '{act: ACT_ACCEPT, cnd: CND_NO_ACCEPT,  target: U_IDLE};
      U_DECODE:   cw = '{act: ACT_NOP,    cnd: CND_IS_LOAD,    target: U_LOADW};
      U_CLASSIFY: cw = '{act: ACT_NOP,    cnd: CND_IS_LETTER,  target: U_LETTER};
      U_POP1:     cw = '{act: ACT_POP1,   cnd: CND_NEXT,       target: U_IDLE};
      U_POP2:     cw = '{act: ACT_POP2,   cnd: CND_NEXT,       target: U_IDLE};
      U_OPSEL:    cw = '{act: ACT_OPSEL,  cnd: CND_NOT_MULDIV, target: U_ALU};
      U_MDINIT:   cw = '{act: ACT_MDINIT, cnd: CND_DIV_ZERO,   target: U_PUSH};
      U_MDSTEP:   cw = '{act: ACT_MDSTEP, cnd: CND_ITER_MORE,  target: U_MDSTEP};
      U_MDFIN:    cw = '{act: ACT_MDFIN,  cnd: CND_ALWAYS,     target: U_PUSH};
      U_ALU:      cw = '{act: ACT_ALU,    cnd: CND_NEXT,       target: U_IDLE};
      U_PUSH:     cw = '{act: ACT_PUSH,   cnd: CND_NOT_LAST,   target: U_IDLE};
      U_RDTOP:    cw = '{act: ACT_RDTOP,  cnd: CND_NEXT,       target: U_IDLE};
      U_HUND:     cw = '{act: ACT_HUND,   cnd: CND_NEXT,       target: U_IDLE};
      U_EMIT:     cw = '{act: ACT_EMIT,   cnd: CND_OUT_FREE,   target: U_IDLE};
      U_REEMIT:   cw = '{act: ACT_NOP,    cnd: CND_ALWAYS,     target: U_EMIT};
      U_LOADW:    cw = '{act: ACT_LOAD,   cnd: CND_ALWAYS,     target: U_IDLE};
      U_LETTER:   cw = '{act: ACT_VAR,    cnd: CND_ALWAYS,     target: U_PUSH};
      default:    cw = '{act: ACT_NOP,    cnd: CND_ALWAYS,     target: U_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/postfix_expression_evaluator_unit.sv -----
// ---------------------------------------------------------------------------
// Postfix expression evaluator
// Microcoded evaluator of postfix expressions over 26 fixed-point variables,
// with a value stack in memory and a shared shift-add / shift-subtract unit.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Contents
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_tvalid/in_tready | load request or one token
//  out_    | output    | out_tvalid/out_tready | hundredths and error code
//
// Requests are taken one at a time in the accept step. A load writes the
// table, a letter pushes its variable, and any other byte pops two entries
// and pushes a result; multiply and divide use the shared shift unit, which
// does one bit a cycle, and divide by zero skips it. A last token then scales
// the top to hundredths and emits it, retried while the output register stays
// full. Reset is synchronous and clears the variable table, stack count and
// error at once; the stack memory needs no clearing pass.
//
`include "assert_macros.svh"

module postfix_expression_evaluator_unit
  import pfx_eval_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // var_index [4:0], var_value [36:5], token_char [44:37], zeros above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // result_hundredths [38:0], error_code [40:39], zeros above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int VAL_W  = 32 + FRAC_BITS;
  localparam int LO_W   = VAL_W + FRAC_BITS;
  localparam int PROD_W = 2 * VAL_W;
  localparam int MAG_W  = PROD_W - FRAC_BITS;
  localparam int HP_W   = VAL_W + 7;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int AW     = $clog2(STACK_DEPTH);
  localparam int IT_W   = $clog2(LO_W + 1);

  localparam logic [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [IT_W-1:0]  IT_MUL   = IT_W'(VAL_W);
  localparam logic [IT_W-1:0]  IT_DIV   = IT_W'(LO_W);

  // Magnitude of a two's complement value, as an unsigned number.
  function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

  // Control state.
  upc_t                upc_r, upc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ERR_W-1:0]    err_r, err_nxt;
  logic                p_ok_r, p_ok_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Captured request.
  logic                req_r, req_nxt;
  logic [VAR_IDX_W-1:0] idx_r, idx_nxt;
  logic [VAR_W-1:0]    val_r, val_nxt;
  logic [TOK_W-1:0]    tok_r, tok_nxt;
  logic                last_r, last_nxt;

  // Datapath registers.
  logic [VAL_W-1:0]    first_r, first_nxt;
  logic [VAL_W-1:0]    second_r, second_nxt;
  logic [VAL_W:0]      acc_r, acc_nxt;
  logic [LO_W-1:0]     lo_r, lo_nxt;
  logic [VAL_W-1:0]    mcand_r, mcand_nxt;
  logic [IT_W-1:0]     it_r, it_nxt;
  logic                neg_r, neg_nxt;
  logic [VAL_W-1:0]    res_r, res_nxt;
  logic [HUND_W-1:0]   hund_r, hund_nxt;
  logic [HUND_W-1:0]   out_hund_r, out_hund_nxt;
  logic [ERR_W-1:0]    out_err_r, out_err_nxt;

  // Variable table and value stack.
  logic [VAR_W-1:0]    tbl_r [NUM_VARS];
  logic [VAL_W-1:0]    stack_mem [STACK_DEPTH];
  logic [VAL_W-1:0]    mem_q_r;

  ctrl_t               cw;
  logic                in_accept;
  logic                out_free;
  logic                emit_fire;
  logic                jump;
  logic                raise;
  logic [ERR_W-1:0]    raise_code;
  logic                tbl_we;
  logic                mem_we;
  logic                mem_re;
  logic [CNT_W-1:0]    cnt_m1;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [TOK_W-1:0]    tok_off;
  logic [VAR_W-1:0]    var_rd;
  logic                is_letter, is_add, is_sub, is_mul, is_div;
  logic [VAL_W:0]      md_sum;
  logic [VAL_W:0]      dv_try;
  logic [VAL_W:0]      dv_diff;
  logic [VAL_W:0]      as_sum;
  logic [PROD_W-1:0]   prod;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-VAL_W:0] mag_hi;
  logic                over_pos, over_neg;
  logic [VAL_W-1:0]    top;
  logic [HP_W-1:0]     top_x;
  logic [HP_W-1:0]     top_p;

  // Microcode fetch and handshake.
  assign cw         = ucode_rom(upc_r);
  assign in_tready  = (cw.act == ACT_ACCEPT);
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign emit_fire  = (cw.act == ACT_EMIT) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-HUND_W-ERR_W){1'b0}}, out_err_r, out_hund_r};

  // Token classes.
  assign is_letter = (tok_r >= ASC_A) && (tok_r <= ASC_Z);
  assign is_add    = (tok_r == ASC_PLUS);
  assign is_sub    = (tok_r == ASC_MINUS);
  assign is_mul    = (tok_r == ASC_STAR);
  assign is_div    = (tok_r == ASC_SLASH);

  // Stack addresses and table read port.
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign rd_addr = cnt_m1[AW-1:0];
  assign wr_addr = cnt_r[AW-1:0];
  assign tok_off = tok_r - ASC_A;
  assign var_rd  = tbl_r[tok_off[VAR_IDX_W-1:0]];

  // Shift unit: multiply adds, divide trial-subtracts.
  assign md_sum  = acc_r + (lo_r[0] ? {1'b0, mcand_r} : '0);
  assign dv_try  = {acc_r[VAL_W-1:0], lo_r[LO_W-1]};
  assign dv_diff = dv_try - {1'b0, mcand_r};

  // Add or subtract with one guard bit.
  assign as_sum = is_sub ? ({second_r[VAL_W-1], second_r} - {first_r[VAL_W-1], first_r})
                         : ({second_r[VAL_W-1], second_r} + {first_r[VAL_W-1], first_r});

  // Magnitude after the shift unit and its saturation tests.
  assign prod     = {acc_r[VAL_W-1:0], lo_r[LO_W-1 -: VAL_W]};
  assign mag      = is_mul ? prod[PROD_W-1:FRAC_BITS] : MAG_W'(lo_r);
  assign mag_hi   = mag[MAG_W-1:VAL_W-1];
  assign over_pos = (mag_hi != '0);
  assign over_neg = over_pos &&
                    !((mag_hi == (MAG_W-VAL_W+1)'(1)) && (mag[VAL_W-2:0] == '0));

  // Top of stack times one hundred, as 64 + 32 + 4.
  assign top   = p_ok_r ? mem_q_r : '0;
  assign top_x = {{(HP_W-VAL_W){top[VAL_W-1]}}, top};
  assign top_p = (top_x << 6) + (top_x << 5) + (top_x << 2);

  // Jump condition.
  always_comb begin
    case (cw.cnd)
      CND_NEXT:       jump = 1'b0;
      CND_ALWAYS:     jump = 1'b1;
      CND_NO_ACCEPT:  jump = !in_accept;
      CND_IS_LOAD:    jump = !req_r;
      CND_IS_LETTER:  jump = is_letter;
      CND_NOT_MULDIV: jump = !(is_mul || is_div);
      CND_DIV_ZERO:   jump = is_div && (first_r == '0);
      CND_ITER_MORE:  jump = (it_r != IT_W'(1));
      CND_NOT_LAST:   jump = !last_r;
      CND_OUT_FREE:   jump = out_free;
      default:        jump = 1'b1;
    endcase
  end

  // Datapath actions.
  always_comb begin
    upc_nxt       = jump ? cw.target : (upc_r + upc_t'(1));
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    p_ok_nxt      = p_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    tok_nxt       = tok_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    mcand_nxt     = mcand_r;
    it_nxt        = it_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    hund_nxt      = hund_r;
    out_hund_nxt  = out_hund_r;
    out_err_nxt   = out_err_r;
    raise         = 1'b0;
    raise_code    = ERR_NONE;
    tbl_we        = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (cw.act) inside
      ACT_ACCEPT: begin
        if (in_accept) begin
          req_nxt  = in_tuser;
          idx_nxt  = in_tdata[VAR_IDX_W-1:0];
          val_nxt  = in_tdata[VAR_IDX_W +: VAR_W];
          tok_nxt  = in_tdata[VAR_IDX_W+VAR_W +: TOK_W];
          last_nxt = in_tlast;
        end
      end
      ACT_NOP: begin
      end
      ACT_LOAD: begin
        tbl_we = (idx_r < VAR_IDX_W'(NUM_VARS));
      end
      ACT_VAR: begin
        res_nxt = {{FRAC_BITS{var_rd[VAR_W-1]}}, var_rd};
      end
      ACT_POP1, ACT_POP2, ACT_RDTOP: begin
        // Read the top entry; an empty stack reads as zero and underflows.
        mem_re = 1'b1;
        if (cw.act == ACT_POP2) begin
          first_nxt = p_ok_r ? mem_q_r : '0;
        end
        if (cnt_r == '0) begin
          p_ok_nxt   = 1'b0;
          raise      = 1'b1;
          raise_code = ERR_UNDERFLOW;
        end else begin
          p_ok_nxt = 1'b1;
          if (cw.act != ACT_RDTOP) begin
            cnt_nxt = cnt_m1;
          end
        end
      end
      ACT_OPSEL: begin
        second_nxt = p_ok_r ? mem_q_r : '0;
      end
      ACT_MDINIT: begin
        neg_nxt = second_r[VAL_W-1] ^ first_r[VAL_W-1];
        acc_nxt = '0;
        if (is_div) begin
          mcand_nxt = mag_of(first_r);
          lo_nxt    = {mag_of(second_r), {FRAC_BITS{1'b0}}};
          it_nxt    = IT_DIV;
          // Division by zero saturates toward the dividend's sign.
          if (first_r == '0) begin
            raise      = 1'b1;
            raise_code = ERR_DIVZERO;
            if (second_r == '0) begin
              res_nxt = '0;
            end else if (second_r[VAL_W-1]) begin
              res_nxt = VAL_MIN;
            end else begin
              res_nxt = VAL_MAX;
            end
          end
        end else begin
          mcand_nxt = mag_of(second_r);
          lo_nxt    = LO_W'(mag_of(first_r));
          it_nxt    = IT_MUL;
        end
      end
      ACT_MDSTEP: begin
        it_nxt = it_r - IT_W'(1);
        if (is_mul) begin
          acc_nxt = {1'b0, md_sum[VAL_W:1]};
          lo_nxt  = {md_sum[0], lo_r[LO_W-1:1]};
        end else if (!dv_diff[VAL_W]) begin
          acc_nxt = dv_diff;
          lo_nxt  = {lo_r[LO_W-2:0], 1'b1};
        end else begin
          acc_nxt = dv_try;
          lo_nxt  = {lo_r[LO_W-2:0], 1'b0};
        end
      end
      ACT_MDFIN: begin
        if (neg_r && over_neg) begin
          res_nxt    = VAL_MIN;
          raise      = 1'b1;
          raise_code = ERR_OVERFLOW;
        end else if (neg_r) begin
          res_nxt = ~mag[VAL_W-1:0] + VAL_W'(1);
        end else if (over_pos) begin
          res_nxt    = VAL_MAX;
          raise      = 1'b1;
          raise_code = ERR_OVERFLOW;
        end else begin
          res_nxt = mag[VAL_W-1:0];
        end
      end
      ACT_ALU: begin
        if (is_add || is_sub) begin
          if (as_sum[VAL_W] != as_sum[VAL_W-1]) begin
            res_nxt    = as_sum[VAL_W] ? VAL_MIN : VAL_MAX;
            raise      = 1'b1;
            raise_code = ERR_OVERFLOW;
          end else begin
            res_nxt = as_sum[VAL_W-1:0];
          end
        end else begin
          res_nxt = '0;
        end
      end
      ACT_PUSH: begin
        // A push onto a full stack is dropped.
        if (cnt_r == CNT_FULL) begin
          raise      = 1'b1;
          raise_code = ERR_OVERFLOW;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ACT_HUND: begin
        hund_nxt = top_p[HP_W-1:FRAC_BITS];
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hund_nxt  = hund_r;
          out_err_nxt   = err_r;
          cnt_nxt       = '0;
          err_nxt       = ERR_NONE;
        end
      end
      default: begin
      end
    endcase

    // The error register keeps the first error raised.
    if (raise && (err_r == ERR_NONE)) begin
      err_nxt = raise_code;
    end
  end

  // Control registers and variable table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_IDLE;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      p_ok_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_VARS; i++) begin
        tbl_r[i] <= '0;
      end
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      p_ok_r      <= p_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (tbl_we) begin
        tbl_r[idx_r] <= val_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    tok_r      <= tok_nxt;
    last_r     <= last_nxt;
    first_r    <= first_nxt;
    second_r   <= second_nxt;
    acc_r      <= acc_nxt;
    lo_r       <= lo_nxt;
    mcand_r    <= mcand_nxt;
    it_r       <= it_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    hund_r     <= hund_nxt;
    out_hund_r <= out_hund_nxt;
    out_err_r  <= out_err_nxt;
  end

  // Value stack memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= res_r;
    end
    if (mem_re) begin
      mem_q_r <= stack_mem[rd_addr];
    end
  end

  // Assertions.
  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= CNT_FULL, "stack count beyond depth")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, !in_tready, "request taken twice")
  `ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_fire,
               out_valid_r && (cnt_r == '0) && (err_r == ERR_NONE), "emit left state")
  `ASSERT_ALWAYS(a_iter_live, clk, rst_n, (upc_r != U_MDSTEP) || (it_r != '0), "count ran out")

endmodule
